// ===== rtl/clt_pkg.sv =====
`timescale 1ns / 1ps

package clt_pkg;

    localparam int IDX_W      = 12;
    localparam int CW         = 32;
    localparam int NORM_MSB   = 14;
    localparam int SQRT_STEPS = 32;
    localparam int QUO_BITS   = 33;

    localparam logic [CW-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [CW-1:0] SAT_MIN = 32'h8000_0000;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_TRI  = 1'b1
    } opcode_t;

    typedef struct packed {
        opcode_t                opcode;
        logic [IDX_W-1:0]       vert_a;
        logic [IDX_W-1:0]       vert_b;
        logic [IDX_W-1:0]       vert_c;
        logic signed [CW-1:0]   coord_x;
        logic signed [CW-1:0]   coord_y;
        logic signed [CW-1:0]   coord_z;
        logic signed [CW-1:0]   density;
    } cmd_t;

    typedef struct packed {
        logic [IDX_W-1:0]       row_index;
        logic [IDX_W-1:0]       col_index;
        logic signed [CW-1:0]   value;
        logic                   degenerate;
        logic                   last;
    } trip_t;

    typedef struct packed {
        logic [IDX_W-1:0]       vi;
        logic [IDX_W-1:0]       vj;
        logic [2:0][CW-1:0]     pi;
        logic [2:0][CW-1:0]     pj;
        logic [2:0][CW-1:0]     pk;
        logic [CW-1:0]          dens;
        logic                   last;
    } corner_t;

    typedef struct packed {
        logic [IDX_W-1:0]       vi;
        logic [IDX_W-1:0]       vj;
        logic [CW-1:0]          pos;
        logic [CW-1:0]          negv;
        logic                   degen;
        logic                   last;
    } weight_t;

    typedef struct packed {
        logic [IDX_W-1:0]       vi;
        logic [IDX_W-1:0]       vj;
        logic                   last;
        logic                   dneg;
        logic [CW-1:0]          dmag;
    } tag_t;

endpackage

// ===== rtl/clt_corner.sv =====
`timescale 1ns / 1ps

module clt_corner
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              in_valid,
    input  clt_pkg::corner_t  corner,
    output logic              out_valid,
    output clt_pkg::weight_t  weight
);

    localparam int SQ = clt_pkg::SQRT_STEPS;
    localparam int QB = clt_pkg::QUO_BITS;

    typedef struct packed {
        clt_pkg::tag_t  tag;
        logic [63:0]    num;
        logic           neg;
        logic           degen;
    } ride_t;

    typedef struct packed {
        logic [QB:0]    rem;
        logic [QB-1:0]  q;
        logic [QB-1:0]  d;
        logic [QB-1:0]  nlo;
        logic           ovf;
        logic           neg;
        logic           degen;
        clt_pkg::tag_t  tag;
    } div_t;

    // stage 1: edge vectors as sign and magnitude
    logic [5:0][31:0]  e_mag;
    logic [5:0]        e_neg;
    logic [32:0]       diff;
    clt_pkg::tag_t     tag_in;

    always_comb
    begin
        diff  = '0;
        e_mag = '0;
        e_neg = '0;
        for (int k = 0; k < 3; k++)
        begin
            diff = {corner.pj[2-k][31], corner.pj[2-k]} - {corner.pk[2-k][31], corner.pk[2-k]};
            e_neg[k] = diff[32];
            e_mag[k] = diff[32] ? 32'(-diff) : diff[31:0];
            diff = {corner.pi[2-k][31], corner.pi[2-k]} - {corner.pk[2-k][31], corner.pk[2-k]};
            e_neg[3+k] = diff[32];
            e_mag[3+k] = diff[32] ? 32'(-diff) : diff[31:0];
        end
        tag_in.vi   = corner.vi;
        tag_in.vj   = corner.vj;
        tag_in.last = corner.last;
        tag_in.dneg = corner.dens[31];
        tag_in.dmag = corner.dens[31] ? 32'(33'd0 - {1'b1, corner.dens}) : corner.dens;
    end

    logic              v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    logic [5:0][31:0]  s1_mag_reg, s2_mag_reg, s3_mag_reg;
    logic [5:0]        s1_neg_reg, s2_neg_reg, s3_neg_reg;
    clt_pkg::tag_t     s1_tag_reg, s2_tag_reg, s3_tag_reg, s4_tag_reg, s5_tag_reg;
    clt_pkg::tag_t     s6_tag_reg, s7_tag_reg;
    logic [31:0]       s2_or_reg;
    logic              s3_up_reg;
    logic [4:0]        s3_amt_reg;
    logic signed [15:0] s4_c_reg [6];
    logic signed [31:0] s5_p_reg [9];
    logic [31:0]       s6_dotm_reg;
    logic              s6_dneg_reg;
    logic [31:0]       s6_crm_reg [3];
    logic [63:0]       s7_sq_reg [3];
    logic [63:0]       s7_num_reg;
    logic              s7_neg_reg;

    // stage 3: leading one of the OR of all magnitudes
    logic [4:0] lead;
    logic       up_next;
    logic [4:0] amt_next;

    always_comb
    begin
        lead = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (s2_or_reg[i])
            begin
                lead = 5'(i);
            end
        end
        up_next  = lead < 5'(clt_pkg::NORM_MSB + 1);
        amt_next = up_next ? 5'(clt_pkg::NORM_MSB) - lead : lead - 5'(clt_pkg::NORM_MSB);
    end

    // stage 4: common shift
    logic signed [15:0] c_next [6];
    logic [31:0]        sh;

    always_comb
    begin
        sh = '0;
        for (int i = 0; i < 6; i++)
        begin
            sh = s3_up_reg ? (s3_mag_reg[i] << s3_amt_reg) : (s3_mag_reg[i] >> s3_amt_reg);
            c_next[i] = s3_neg_reg[i] ? -$signed({1'b0, sh[14:0]}) : $signed({1'b0, sh[14:0]});
        end
    end

    // stage 6: dot and cross sums
    logic signed [33:0] dot;
    logic signed [32:0] cr [3];
    logic [31:0]        crm_next [3];

    always_comb
    begin
        dot   = 34'(s5_p_reg[0]) + 34'(s5_p_reg[1]) + 34'(s5_p_reg[2]);
        cr[0] = 33'(s5_p_reg[3]) - 33'(s5_p_reg[4]);
        cr[1] = 33'(s5_p_reg[5]) - 33'(s5_p_reg[6]);
        cr[2] = 33'(s5_p_reg[7]) - 33'(s5_p_reg[8]);
        for (int k = 0; k < 3; k++)
        begin
            crm_next[k] = cr[k][32] ? 32'(-cr[k]) : cr[k][31:0];
        end
    end

    logic [63:0] sq_n_reg [SQ+1];
    logic [63:0] sq_r_reg [SQ+1];
    ride_t       sq_ride_reg [SQ+1];
    logic        sq_v_reg [SQ+1];
    div_t        dv_reg [QB+1];
    logic        dv_v_reg [QB+1];
    logic [63:0] n2_next;

    assign n2_next = s7_sq_reg[0] + s7_sq_reg[1] + s7_sq_reg[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            v5_reg      <= 1'b0;
            v6_reg      <= 1'b0;
            v7_reg      <= 1'b0;
            sq_v_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg      <= in_valid;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            v4_reg      <= v3_reg;
            v5_reg      <= v4_reg;
            v6_reg      <= v5_reg;
            v7_reg      <= v6_reg;
            sq_v_reg[0] <= v7_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_mag_reg <= e_mag;
            s1_neg_reg <= e_neg;
            s1_tag_reg <= tag_in;

            s2_mag_reg <= s1_mag_reg;
            s2_neg_reg <= s1_neg_reg;
            s2_tag_reg <= s1_tag_reg;
            s2_or_reg  <= s1_mag_reg[0] | s1_mag_reg[1] | s1_mag_reg[2]
                        | s1_mag_reg[3] | s1_mag_reg[4] | s1_mag_reg[5];

            s3_mag_reg <= s2_mag_reg;
            s3_neg_reg <= s2_neg_reg;
            s3_tag_reg <= s2_tag_reg;
            s3_up_reg  <= up_next;
            s3_amt_reg <= amt_next;

            s4_c_reg   <= c_next;
            s4_tag_reg <= s3_tag_reg;

            s5_p_reg[0] <= s4_c_reg[0] * s4_c_reg[3];
            s5_p_reg[1] <= s4_c_reg[1] * s4_c_reg[4];
            s5_p_reg[2] <= s4_c_reg[2] * s4_c_reg[5];
            s5_p_reg[3] <= s4_c_reg[1] * s4_c_reg[5];
            s5_p_reg[4] <= s4_c_reg[2] * s4_c_reg[4];
            s5_p_reg[5] <= s4_c_reg[2] * s4_c_reg[3];
            s5_p_reg[6] <= s4_c_reg[0] * s4_c_reg[5];
            s5_p_reg[7] <= s4_c_reg[0] * s4_c_reg[4];
            s5_p_reg[8] <= s4_c_reg[1] * s4_c_reg[3];
            s5_tag_reg  <= s4_tag_reg;

            s6_dotm_reg <= dot[33] ? 32'(-dot) : dot[31:0];
            s6_dneg_reg <= dot[33];
            s6_crm_reg  <= crm_next;
            s6_tag_reg  <= s5_tag_reg;

            for (int k = 0; k < 3; k++)
            begin
                s7_sq_reg[k] <= 64'(s6_crm_reg[k]) * 64'(s6_crm_reg[k]);
            end
            s7_num_reg <= 64'(s6_dotm_reg) * 64'(s6_tag_reg.dmag);
            s7_neg_reg <= s6_dneg_reg ^ s6_tag_reg.dneg;
            s7_tag_reg <= s6_tag_reg;

            sq_n_reg[0]          <= n2_next;
            sq_r_reg[0]          <= '0;
            sq_ride_reg[0].tag   <= s7_tag_reg;
            sq_ride_reg[0].num   <= s7_num_reg;
            sq_ride_reg[0].neg   <= s7_neg_reg;
            sq_ride_reg[0].degen <= (n2_next == 64'd0);
        end
    end

    // square root, one result bit per stage
    for (genvar s = 0; s < SQ; s++)
    begin : g_sqrt
        localparam logic [63:0] BITV = 64'(1) << (62 - 2*s);
        logic [63:0] t;
        logic        ge;

        assign t  = sq_r_reg[s] + BITV;
        assign ge = sq_n_reg[s] >= t;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_v_reg[s+1] <= 1'b0;
            end
            else if (adv)
            begin
                sq_v_reg[s+1] <= sq_v_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_n_reg[s+1]    <= ge ? sq_n_reg[s] - t : sq_n_reg[s];
                sq_r_reg[s+1]    <= ge ? (sq_r_reg[s] >> 1) + BITV : sq_r_reg[s] >> 1;
                sq_ride_reg[s+1] <= sq_ride_reg[s];
            end
        end
    end

    // divider setup: q = floor((num + norm) / (2 * norm))
    logic [31:0]   norm;
    logic [63:0]   numer;
    logic [QB-1:0] denom;
    logic          ovf;

    assign norm  = sq_r_reg[SQ][31:0];
    assign numer = sq_ride_reg[SQ].num + 64'(norm);
    assign denom = {norm, 1'b0};
    assign ovf   = {2'b00, numer[63:QB]} >= denom;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_v_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            dv_v_reg[0] <= sq_v_reg[SQ];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_reg[0].rem   <= ovf ? '0 : {3'b000, numer[63:QB]};
            dv_reg[0].q     <= '0;
            dv_reg[0].d     <= denom;
            dv_reg[0].nlo   <= numer[QB-1:0];
            dv_reg[0].ovf   <= ovf;
            dv_reg[0].neg   <= sq_ride_reg[SQ].neg;
            dv_reg[0].degen <= sq_ride_reg[SQ].degen;
            dv_reg[0].tag   <= sq_ride_reg[SQ].tag;
        end
    end

    // restoring division, one quotient bit per stage
    for (genvar b = 0; b < QB; b++)
    begin : g_div
        logic [QB:0] t;
        logic        ge;
        div_t        nx;

        assign t  = {dv_reg[b].rem[QB-1:0], dv_reg[b].nlo[QB-1-b]};
        assign ge = t >= {1'b0, dv_reg[b].d};

        always_comb
        begin
            nx     = dv_reg[b];
            nx.rem = ge ? t - {1'b0, dv_reg[b].d} : t;
            nx.q   = {dv_reg[b].q[QB-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_v_reg[b+1] <= 1'b0;
            end
            else if (adv)
            begin
                dv_v_reg[b+1] <= dv_v_reg[b];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_reg[b+1] <= nx;
            end
        end
    end

    function automatic logic [31:0] sat(input logic neg, input logic big, input logic [QB-1:0] q);
        logic [31:0] r;
        if (neg)
        begin
            r = (big || q > {1'b0, clt_pkg::SAT_MIN}) ? clt_pkg::SAT_MIN : 32'(33'd0 - q);
        end
        else
        begin
            r = (big || q > {1'b0, clt_pkg::SAT_MAX}) ? clt_pkg::SAT_MAX : q[31:0];
        end
        return r;
    endfunction

    logic             w_v_reg;
    clt_pkg::weight_t w_reg;
    div_t             dl;

    assign dl = dv_reg[QB];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            w_v_reg <= dv_v_reg[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            w_reg.vi    <= dl.tag.vi;
            w_reg.vj    <= dl.tag.vj;
            w_reg.last  <= dl.tag.last;
            w_reg.degen <= dl.degen;
            w_reg.pos   <= dl.degen ? '0 : sat(dl.neg, dl.ovf, dl.q);
            w_reg.negv  <= dl.degen ? '0 : sat(!dl.neg, dl.ovf, dl.q);
        end
    end

    assign out_valid = w_v_reg;
    assign weight    = w_reg;

endmodule

// ===== rtl/cotangent_laplace_triplets.sv =====
`timescale 1ns / 1ps

// Cotangent Laplacian triplet generator.
// cmd channel (cmd_valid/cmd_ready/cmd): opcode OP_LOAD writes one vertex
// (x, y, z) into the vertex store in the cycle it is accepted; OP_TRI starts
// one triangle. A triangle holds cmd_ready low through phases RD_A, RD_B,
// RD_C, CAP, C0, C1 and C2: three vertex store reads on its single read port,
// then one corner issued per cycle into the corner pipeline while it advances.
// trip channel (trip_valid/trip_ready/trip): twelve triplets per triangle,
// four per corner, last set on the twelfth.
// The corner pipeline has 75 stages, most of them the 32-step square root
// and the 33-step divider. The output register sends one triplet per cycle
// while trip_ready is high, so the sustained rate is set by the trip port.
// Reset clears all valid bits and the sequencer; the vertex store is not
// cleared and must be loaded before use. When trip_ready is low, the output
// register holds its triplet, the whole corner pipeline freezes once its
// last stage is full, and cmd_ready drops behind it; nothing is lost.
module cotangent_laplace_triplets
#(
    parameter int VERTEX_DEPTH = 4096
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_ready,
    input  clt_pkg::cmd_t   cmd,
    output logic            trip_valid,
    input  logic            trip_ready,
    output clt_pkg::trip_t  trip
);

    localparam int AW = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;

    typedef enum logic [6:0] {
        PH_RD_A = 7'b000_0001,
        PH_RD_B = 7'b000_0010,
        PH_RD_C = 7'b000_0100,
        PH_CAP  = 7'b000_1000,
        PH_C0   = 7'b001_0000,
        PH_C1   = 7'b010_0000,
        PH_C2   = 7'b100_0000
    } phase_t;

    localparam logic [1:0] TRIP_IJ = 2'd0;
    localparam logic [1:0] TRIP_JI = 2'd1;
    localparam logic [1:0] TRIP_II = 2'd2;
    localparam logic [1:0] TRIP_JJ = 2'd3;

    function automatic logic idx_ok(input logic [clt_pkg::IDX_W-1:0] idx);
        return int'(idx) < VERTEX_DEPTH;
    endfunction

    logic                       busy_reg;
    phase_t                     ph_reg;
    clt_pkg::cmd_t              tri_reg;
    logic [95:0]                pos_reg [3];
    logic [95:0]                mem [VERTEX_DEPTH];
    logic [95:0]                rd_reg;
    logic                       rd_ok_reg;
    logic [95:0]                rd_word;
    logic [clt_pkg::IDX_W-1:0]  rd_idx;
    logic                       cmd_accept;
    logic                       adv;
    logic                       c_valid;
    clt_pkg::corner_t           corner;
    logic                       w_valid;
    clt_pkg::weight_t           w;
    logic                       ser_v_reg;
    logic [1:0]                 cnt_reg;
    clt_pkg::weight_t           ser_reg;
    logic                       ser_take;

    assign cmd_ready  = !busy_reg;
    assign cmd_accept = cmd_valid && cmd_ready;
    assign rd_word    = rd_ok_reg ? rd_reg : '0;
    assign c_valid    = busy_reg && (ph_reg == PH_C0 || ph_reg == PH_C1 || ph_reg == PH_C2);

    always_comb
    begin
        unique case (ph_reg)
            PH_RD_A: rd_idx = tri_reg.vert_a;
            PH_RD_B: rd_idx = tri_reg.vert_b;
            default: rd_idx = tri_reg.vert_c;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd_accept && cmd.opcode == clt_pkg::OP_LOAD && idx_ok(cmd.vert_a))
        begin
            mem[AW'(cmd.vert_a)] <= {cmd.coord_x, cmd.coord_y, cmd.coord_z};
        end
        rd_reg    <= mem[AW'(rd_idx)];
        rd_ok_reg <= idx_ok(rd_idx);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            ph_reg   <= PH_RD_A;
        end
        else if (cmd_accept && cmd.opcode == clt_pkg::OP_TRI)
        begin
            busy_reg <= 1'b1;
            ph_reg   <= PH_RD_A;
        end
        else if (busy_reg)
        begin
            unique case (ph_reg)
                PH_RD_A: ph_reg <= PH_RD_B;
                PH_RD_B: ph_reg <= PH_RD_C;
                PH_RD_C: ph_reg <= PH_CAP;
                PH_CAP:  ph_reg <= PH_C0;
                PH_C0:
                begin
                    if (adv)
                    begin
                        ph_reg <= PH_C1;
                    end
                end
                PH_C1:
                begin
                    if (adv)
                    begin
                        ph_reg <= PH_C2;
                    end
                end
                default:
                begin
                    if (adv)
                    begin
                        busy_reg <= 1'b0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_accept && cmd.opcode == clt_pkg::OP_TRI)
        begin
            tri_reg <= cmd;
        end
        if (busy_reg && ph_reg == PH_RD_B)
        begin
            pos_reg[0] <= rd_word;
        end
        if (busy_reg && ph_reg == PH_RD_C)
        begin
            pos_reg[1] <= rd_word;
        end
        if (busy_reg && ph_reg == PH_CAP)
        begin
            pos_reg[2] <= rd_word;
        end
    end

    always_comb
    begin
        corner.dens = tri_reg.density;
        corner.last = (ph_reg == PH_C2);
        unique case (ph_reg)
            PH_C0:
            begin
                corner.vi = tri_reg.vert_a;
                corner.vj = tri_reg.vert_b;
                corner.pi = pos_reg[0];
                corner.pj = pos_reg[1];
                corner.pk = pos_reg[2];
            end
            PH_C1:
            begin
                corner.vi = tri_reg.vert_b;
                corner.vj = tri_reg.vert_c;
                corner.pi = pos_reg[1];
                corner.pj = pos_reg[2];
                corner.pk = pos_reg[0];
            end
            default:
            begin
                corner.vi = tri_reg.vert_c;
                corner.vj = tri_reg.vert_a;
                corner.pi = pos_reg[2];
                corner.pj = pos_reg[0];
                corner.pk = pos_reg[1];
            end
        endcase
    end

    clt_corner u_corner
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (c_valid),
        .corner    (corner),
        .out_valid (w_valid),
        .weight    (w)
    );

    assign ser_take = !ser_v_reg || (trip_ready && cnt_reg == TRIP_JJ);
    assign adv      = !w_valid || ser_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ser_v_reg <= 1'b0;
            cnt_reg   <= TRIP_IJ;
        end
        else if (adv && w_valid)
        begin
            ser_v_reg <= 1'b1;
            cnt_reg   <= TRIP_IJ;
        end
        else if (ser_take)
        begin
            ser_v_reg <= 1'b0;
        end
        else if (trip_ready)
        begin
            cnt_reg <= cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && w_valid)
        begin
            ser_reg <= w;
        end
    end

    assign trip_valid = ser_v_reg;

    always_comb
    begin
        trip.degenerate = ser_reg.degen;
        trip.last       = ser_reg.last && (cnt_reg == TRIP_JJ);
        unique case (cnt_reg)
            TRIP_IJ:
            begin
                trip.row_index = ser_reg.vi;
                trip.col_index = ser_reg.vj;
                trip.value     = ser_reg.negv;
            end
            TRIP_JI:
            begin
                trip.row_index = ser_reg.vj;
                trip.col_index = ser_reg.vi;
                trip.value     = ser_reg.negv;
            end
            TRIP_II:
            begin
                trip.row_index = ser_reg.vi;
                trip.col_index = ser_reg.vi;
                trip.value     = ser_reg.pos;
            end
            default:
            begin
                trip.row_index = ser_reg.vj;
                trip.col_index = ser_reg.vj;
                trip.value     = ser_reg.pos;
            end
        endcase
    end

`ifndef SYNTH
    a_last_corner_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && ph_reg == PH_C2 && adv) |=> !busy_reg)
        else $error("sequencer still busy after last corner");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (trip_valid && trip.degenerate) |-> (trip.value == '0))
        else $error("degenerate triplet with nonzero value");

    a_last_diag: assert property (@(posedge clk) disable iff (!rst_n)
        (trip_valid && trip.last) |-> (trip.row_index == trip.col_index))
        else $error("last triplet is not a diagonal entry");
`endif

endmodule

// ===== tb/cotangent_laplace_triplets_checker.sv =====
`timescale 1ns / 1ps

module cotangent_laplace_triplets_checker
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    input  logic            cmd_ready,
    input  clt_pkg::cmd_t   cmd,
    input  logic            trip_valid,
    input  logic            trip_ready,
    input  clt_pkg::trip_t  trip,
    output int              fail_count,
    output int              pending
);

    logic signed [31:0] vx [4096];
    logic signed [31:0] vy [4096];
    logic signed [31:0] vz [4096];
    clt_pkg::trip_t expected_trips [$];

    initial
    begin
        fail_count = 0;
        pending = 0;
    end

    function automatic logic [63:0] mag(input longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic [31:0] saturate(input logic neg, input logic [63:0] q);
        if (neg)
            return q > 64'h8000_0000 ? 32'h8000_0000 : 32'(-longint'(q));
        return q > 64'h7FFF_FFFF ? 32'h7FFF_FFFF : q[31:0];
    endfunction

    task automatic add_trip(input logic [11:0] row, input logic [11:0] col,
                            input logic [31:0] value, input logic degen,
                            input logic last);
        clt_pkg::trip_t t;
        t.row_index = row;
        t.col_index = col;
        t.value = value;
        t.degenerate = degen;
        t.last = last;
        expected_trips.insert(expected_trips.size(), t);
    endtask

    task automatic predict_triangle(input clt_pkg::cmd_t c);
        logic [11:0] ids [3];
        longint p [3][3];
        longint e [6];
        longint dotp;
        longint cr [3];
        logic [63:0] m, a, n2, q, den, num;
        int dn, up;
        logic neg, degen;
        logic [31:0] pv, nv;
        logic [11:0] vi, vj;
        ids[0] = c.vert_a;
        ids[1] = c.vert_b;
        ids[2] = c.vert_c;
        for (int i = 0; i < 3; i++)
        begin
            for (int s = 0; s < 3; s++)
            begin
                p[s][0] = vx[ids[(i + s) % 3]];
                p[s][1] = vy[ids[(i + s) % 3]];
                p[s][2] = vz[ids[(i + s) % 3]];
            end
            for (int k = 0; k < 3; k++)
            begin
                e[k] = p[1][k] - p[2][k];
                e[3 + k] = p[0][k] - p[2][k];
            end
            m = 0;
            for (int k = 0; k < 6; k++)
                if (mag(e[k]) > m)
                    m = mag(e[k]);
            if (m != 0)
            begin
                dn = 0;
                up = 0;
                while ((m >> dn) >= 64'd32768)
                    dn++;
                if (dn == 0)
                    while ((m << (up + 1)) < 64'd32768)
                        up++;
                for (int k = 0; k < 6; k++)
                begin
                    a = mag(e[k]);
                    a = dn != 0 ? (a >> dn) : (a << up);
                    e[k] = e[k] < 0 ? -longint'(a) : longint'(a);
                end
            end
            dotp = e[0] * e[3] + e[1] * e[4] + e[2] * e[5];
            cr[0] = e[1] * e[5] - e[2] * e[4];
            cr[1] = e[2] * e[3] - e[0] * e[5];
            cr[2] = e[0] * e[4] - e[1] * e[3];
            n2 = 0;
            for (int k = 0; k < 3; k++)
                n2 += mag(cr[k]) * mag(cr[k]);
            degen = (n2 == 0);
            q = 0;
            neg = 0;
            if (!degen)
            begin
                den = 2 * int_sqrt(n2);
                num = mag(dotp) * mag(longint'(c.density));
                q = (2 * num + den) / (2 * den);
                neg = (dotp < 0) != (c.density < 0);
            end
            pv = saturate(neg, q);
            nv = saturate(!neg, q);
            vi = ids[i];
            vj = ids[(i + 1) % 3];
            add_trip(vi, vj, nv, degen, 1'b0);
            add_trip(vj, vi, nv, degen, 1'b0);
            add_trip(vi, vi, pv, degen, 1'b0);
            add_trip(vj, vj, pv, degen, i == 2);
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("mismatch: %s", what);
        fail_count++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_valid && cmd_ready)
            begin
                if (cmd.opcode == clt_pkg::OP_LOAD)
                begin
                    vx[cmd.vert_a] = cmd.coord_x;
                    vy[cmd.vert_a] = cmd.coord_y;
                    vz[cmd.vert_a] = cmd.coord_z;
                end
                else
                    predict_triangle(cmd);
            end
            if (trip_valid && trip_ready)
            begin
                if (expected_trips.size() == 0)
                    report_mismatch($sformatf("unexpected triplet %p", trip));
                else
                begin
                    if (trip !== expected_trips[0])
                        report_mismatch($sformatf("got %p want %p", trip,
                            expected_trips[0]));
                    void'(expected_trips.pop_front());
                end
            end
        end
        pending = expected_trips.size();
    end

endmodule

// ===== tb/cotangent_laplace_triplets_test.sv =====
`timescale 1ns / 1ps

module cotangent_laplace_triplets_test;

    logic clk;
    logic rst_n;
    logic cmd_valid;
    logic cmd_ready;
    clt_pkg::cmd_t cmd;
    logic trip_valid;
    logic trip_ready;
    clt_pkg::trip_t trip;
    int fail_count;
    int pending;
    int cycle_count;
    logic calm;
    logic [11:0] loaded [$];

    cotangent_laplace_triplets dut (
        .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
        .cmd(cmd), .trip_valid(trip_valid), .trip_ready(trip_ready), .trip(trip)
    );

    cotangent_laplace_triplets_checker checker_i (
        .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
        .cmd(cmd), .trip_valid(trip_valid), .trip_ready(trip_ready), .trip(trip),
        .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(negedge clk)
        trip_ready <= calm || ($urandom_range(99) >= 31);

    task automatic send_item(input clt_pkg::cmd_t c);
        while (!calm && $urandom_range(99) < 31)
        begin
            cmd_valid <= 1'b0;
            @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd <= c;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'(int'($urandom_range(2000)) - 1000) << 16;
            2: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
            default: return 32'($urandom_range(255)) << $urandom_range(24);
        endcase
    endfunction

    task automatic load_vertex(input logic [11:0] idx, input logic [31:0] x,
                               input logic [31:0] y, input logic [31:0] z);
        clt_pkg::cmd_t c;
        c = '{clt_pkg::OP_LOAD, idx, 12'($urandom), 12'($urandom), x, y, z, $urandom};
        send_item(c);
        loaded.insert(loaded.size(), idx);
    endtask

    task automatic send_triangle(input logic [11:0] a, input logic [11:0] b,
                                 input logic [11:0] d, input logic [31:0] dens);
        clt_pkg::cmd_t c;
        c = '{clt_pkg::OP_TRI, a, b, d, $urandom, $urandom, $urandom, dens};
        send_item(c);
    endtask

    function automatic logic [11:0] pick();
        return loaded[$urandom_range(loaded.size() - 1)];
    endfunction

    initial
    begin
        rst_n = 1'b0;
        cmd_valid = 1'b0;
        cmd = '0;
        trip_ready = 1'b0;
        calm = 1'b0;
        cycle_count = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        load_vertex(12'd0, 32'h0, 32'h0, 32'h0);
        load_vertex(12'd4095, 32'h0001_0000, 32'h0, 32'h0);
        load_vertex(12'd1, 32'h0, 32'h0001_0000, 32'h0);
        load_vertex(12'd2, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        load_vertex(12'd3, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        load_vertex(12'd4, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
        load_vertex(12'd5, 32'h0000_0001, 32'h0, 32'h0000_0002);
        send_triangle(12'd0, 12'd4095, 12'd1, 32'h0001_0000);
        send_triangle(12'd0, 12'd4095, 12'd1, 32'h7FFF_FFFF);
        send_triangle(12'd0, 12'd4095, 12'd1, 32'h8000_0000);
        send_triangle(12'd0, 12'd0, 12'd1, 32'h0001_0000);
        send_triangle(12'd2, 12'd3, 12'd0, 32'hFFFF_0000);
        send_triangle(12'd2, 12'd3, 12'd4, 32'h7FFF_FFFF);
        send_triangle(12'd5, 12'd0, 12'd4, 32'h8000_0000);
        send_triangle(12'd3, 12'd4, 12'd5, 32'h0);
        send_triangle(12'd4095, 12'd4095, 12'd4095, 32'h1234_5678);

        cmd_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);

        for (int n = 0; n < 220; n++)
        begin
            calm = (n >= 60 && n < 100);
            if (loaded.size() < 3 || $urandom_range(99) < 25)
                load_vertex(12'($urandom), rand_coord(), rand_coord(), rand_coord());
            else if ($urandom_range(9) == 0)
                send_triangle(pick(), pick(), pick(), $urandom);
            else
                send_triangle(pick(), pick(), pick(),
                    $urandom_range(1) ? $urandom : 32'($urandom_range(1 << 18)));
        end
        calm = 1'b0;

        cmd_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/clt_pkg.sv
rtl/clt_corner.sv
rtl/cotangent_laplace_triplets.sv
tb/cotangent_laplace_triplets_checker.sv
tb/cotangent_laplace_triplets_test.sv
